// ----- rtl/core/hrfe_pkg.sv -----
`timescale 1ns / 1ps

package hrfe_pkg;

    localparam int MAX_REPORT_BYTES_DEF = 64;
    localparam int FIELD_MAX_BITS_DEF   = 32;

    localparam int FIELD_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ID      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_BIT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGN_EXTEND   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RELATIVE_MODE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED_BITS = 3'd5;

    typedef struct packed {
        logic               handled;
        logic               size_error;
        logic               value_changed;
        logic               event_res;
        logic [FIELD_W-1:0] field_value;
        logic [FIELD_W-1:0] generation;
        logic [FIELD_W-1:0] change_time;
    } result_t;

endpackage

// ----- rtl/core/hid_report_field_extractor.sv -----
`timescale 1ns / 1ps
// A report's result goes into the output register, or into the skid stage while one waits.
// Throughput: one report byte per cycle; a result register plus a one-entry skid stage
// keep bytes flowing while a result waits, so byte_stall rises only when both are full.
// Reset (rst_n low, asynchronous) clears the byte counter, the field accumulator, the stored
// value, the generation counter, the event timestamp and all handshake state, and returns the
// configuration registers to their defaults (field width 1, all others zero).
module hid_report_field_extractor
    import hrfe_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF,
    parameter int FIELD_MAX_BITS   = FIELD_MAX_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  logic [7:0]             report_tag,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic [FIELD_W-1:0]     time_stamp,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   handled,
    output logic                   size_error,
    output logic                   value_changed,
    output logic                   event_res,
    output logic [FIELD_W-1:0]     field_value,
    output logic [FIELD_W-1:0]     generation,
    output logic [FIELD_W-1:0]     change_time
);

    localparam int CNT_W = $clog2(MAX_REPORT_BYTES + 1);
    localparam int LEN_W = (CNT_W + 3 > CFG_DATA_W) ? CNT_W + 3 : CFG_DATA_W;
    localparam int REL_W = LEN_W + 2;

    // Configuration registers.
    logic [7:0]            match_id_reg;
    logic [8:0]            start_bit_reg;
    logic [5:0]            width_cfg_reg;
    logic                  sign_ext_reg;
    logic                  relative_reg;
    logic [CFG_DATA_W-1:0] required_bits_reg;

    // Report state.
    logic [CNT_W-1:0]   byte_count_reg,   byte_count_next;
    logic [FIELD_W-1:0] field_accum_reg,  field_accum_next;
    logic [FIELD_W-1:0] stored_value_reg, stored_value_next;
    logic [FIELD_W-1:0] event_time_reg,   event_time_next;
    logic [FIELD_W-1:0] update_count_reg, update_count_next;

    // Output register and skid stage.
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg,        out_next;
    result_t skid_reg,       skid_next;

    logic               byte_acc;
    logic               out_pop;
    logic               room;
    logic [5:0]         eff_w;
    logic [FIELD_W-1:0] gathered;
    logic [FIELD_W-1:0] accum_new;
    logic [FIELD_W-1:0] ext_mask;
    logic [FIELD_W-1:0] value_new;
    logic [CNT_W-1:0]   count_new;
    logic [LEN_W-1:0]   len_bits;
    logic signed [REL_W-1:0] rel;
    logic               sign_bit;
    logic               is_short;
    logic               tag_match;
    logic               take;
    logic               changed;
    logic               raise_event;
    result_t            res;

    assign cfg_ready  = 1'b1;
    assign byte_stall = skid_valid_reg;
    assign byte_acc   = byte_valid && !byte_stall;
    assign out_pop    = out_valid_reg && !result_stall;

    assign eff_w = (width_cfg_reg > 6'(FIELD_MAX_BITS)) ? 6'(FIELD_MAX_BITS) : width_cfg_reg;
    assign room  = byte_count_reg < CNT_W'(MAX_REPORT_BYTES);

    // Offset of this byte's bit 0 relative to the field's first bit.
    assign rel = $signed(REL_W'({byte_count_reg, 3'b000})) - $signed(REL_W'(start_bit_reg));

    always_comb
    begin
        logic signed [REL_W-1:0] src;
        for (int j = 0; j < FIELD_W; j++)
        begin
            src = $signed(REL_W'(j)) - rel;
            gathered[j] = room && (src >= 0) && (src < 8) && (6'(j) < eff_w)
                          && data_byte[src[2:0]];
            ext_mask[j] = (6'(j) >= eff_w);
        end
    end

    assign accum_new = field_accum_reg | gathered;
    assign count_new = byte_count_reg + CNT_W'(room);
    assign len_bits  = LEN_W'({count_new, 3'b000});
    assign sign_bit  = accum_new[5'(eff_w - 6'd1)];
    assign value_new = (sign_ext_reg && eff_w != 6'd0 && eff_w < 6'd32 && sign_bit)
                     ? (accum_new | ext_mask) : accum_new;

    assign tag_match   = report_tag == match_id_reg;
    assign is_short    = required_bits_reg != '0 && len_bits < LEN_W'(required_bits_reg);
    assign take        = tag_match && !is_short;
    assign changed     = take && eff_w != 6'd0 && value_new != stored_value_reg;
    assign raise_event = take && (changed || relative_reg);

    always_comb
    begin
        stored_value_next = changed ? value_new : stored_value_reg;
        event_time_next   = raise_event ? time_stamp : event_time_reg;
        update_count_next = take ? update_count_reg + 32'd2 : update_count_reg;
        byte_count_next   = last_byte ? '0 : count_new;
        field_accum_next  = last_byte ? '0 : accum_new;

        res.handled       = take;
        res.size_error    = tag_match && is_short;
        res.value_changed = changed;
        res.event_res     = raise_event;
        res.field_value   = stored_value_next;
        res.generation    = update_count_next;
        res.change_time   = event_time_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_pop || !out_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (byte_acc && last_byte)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_id_reg      <= '0;
            start_bit_reg     <= '0;
            width_cfg_reg     <= 6'd1;
            sign_ext_reg      <= 1'b0;
            relative_reg      <= 1'b0;
            required_bits_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MATCH_ID:      match_id_reg      <= cfg_data[7:0];
                REG_START_BIT:     start_bit_reg     <= cfg_data[8:0];
                REG_FIELD_WIDTH:   width_cfg_reg     <= cfg_data[5:0];
                REG_SIGN_EXTEND:   sign_ext_reg      <= cfg_data[0];
                REG_RELATIVE_MODE: relative_reg      <= cfg_data[0];
                REG_REQUIRED_BITS: required_bits_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            field_accum_reg  <= '0;
            stored_value_reg <= '0;
            event_time_reg   <= '0;
            update_count_reg <= '0;
        end
        else if (byte_acc)
        begin
            byte_count_reg  <= byte_count_next;
            field_accum_reg <= field_accum_next;
            if (last_byte)
            begin
                stored_value_reg <= stored_value_next;
                event_time_reg   <= event_time_next;
                update_count_reg <= update_count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid  = out_valid_reg;
    assign handled       = out_reg.handled;
    assign size_error    = out_reg.size_error;
    assign value_changed = out_reg.value_changed;
    assign event_res     = out_reg.event_res;
    assign field_value   = out_reg.field_value;
    assign generation    = out_reg.generation;
    assign change_time   = out_reg.change_time;

    // The skid stage only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    // A last byte always leaves a result in the output register.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_acc && last_byte |=> out_valid_reg)
        else $error("last byte accepted without a result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(MAX_REPORT_BYTES))
        else $error("byte counter ran past the report limit");

    a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.event_res || out_reg.value_changed)
            |-> out_reg.handled && !out_reg.size_error)
        else $error("event or change flagged on a report that was not handled");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import hrfe_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam int STALL_PCT      = 23;
    localparam int ITEM_TARGET    = 750;
    localparam int HOLD_CYCLES    = 80;
    localparam int IDLE_LIMIT     = 4000;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   byte_valid   = 1'b0;
    logic                   byte_stall;
    logic [7:0]             report_tag   = '0;
    logic [7:0]             data_byte    = '0;
    logic                   last_byte    = 1'b0;
    logic [FIELD_W-1:0]     time_stamp   = '0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   handled;
    logic                   size_error;
    logic                   value_changed;
    logic                   event_res;
    logic [FIELD_W-1:0]     field_value;
    logic [FIELD_W-1:0]     generation;
    logic [FIELD_W-1:0]     change_time;

    hid_report_field_extractor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .report_tag   (report_tag),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .time_stamp   (time_stamp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .handled      (handled),
        .size_error   (size_error),
        .value_changed(value_changed),
        .event_res    (event_res),
        .field_value  (field_value),
        .generation   (generation),
        .change_time  (change_time)
    );

    // Shadow of the register file.
    logic [7:0] sel_id    = '0;
    logic [8:0] sel_start = '0;
    logic [5:0] sel_width = 6'd1;
    logic       sel_sext  = 1'b0;
    logic       sel_rel   = 1'b0;
    logic [9:0] sel_req   = '0;

    // Shadow of the extraction state.
    logic [6:0]  cnt_bytes  = '0;
    logic [31:0] acc_bits   = '0;
    logic [31:0] held_value = '0;
    logic [31:0] evt_time   = '0;
    logic [31:0] gen_count  = '0;

    result_t pending_results[$];

    int  mismatches  = 0;
    int  bytes_taken = 0;
    int  n_handled   = 0;
    int  n_short     = 0;
    int  n_other     = 0;
    int  n_events    = 0;
    int  hold_asks   = 0;
    int  hold_served = 0;
    int  hold_left   = 0;
    int  idle_cycles = 0;
    bit  quiet       = 1'b0;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        logic [7:0]             tag;
        logic [7:0]             data;
        logic                   last;
        logic [31:0]            ts;
        bit                     typed;
        result_t                want;
    } stim_row_t;

    stim_row_t directed[$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic store_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MATCH_ID:      sel_id    = val[7:0];
            REG_START_BIT:     sel_start = val[8:0];
            REG_FIELD_WIDTH:   sel_width = val[5:0];
            REG_SIGN_EXTEND:   sel_sext  = val[0];
            REG_RELATIVE_MODE: sel_rel   = val[0];
            REG_REQUIRED_BITS: sel_req   = val[9:0];
            default: ;
        endcase
    endtask

    // Gathers one byte into the field and, at the last byte, works out the result.
    task automatic extract_field(input logic [7:0] tag, input logic [7:0] data, input logic last,
                                 input logic [31:0] ts, output bit done, output result_t r);
        int          w;
        int          pos;
        int          start_i;
        logic [31:0] v;
        w       = (sel_width > FIELD_MAX_BITS_DEF) ? FIELD_MAX_BITS_DEF : int'(sel_width);
        start_i = int'(sel_start);
        r       = '0;
        done    = last;
        if (cnt_bytes < MAX_REPORT_BYTES_DEF)
        begin
            for (int i = 0; i < 8; i++)
            begin
                pos = int'(cnt_bytes) * 8 + i;
                if (pos >= start_i && pos - start_i < w)
                    acc_bits[(pos - start_i) & 31] = acc_bits[(pos - start_i) & 31] | data[i];
            end
            cnt_bytes++;
        end
        if (!last)
            return;
        if (tag == sel_id)
        begin
            if (sel_req != 0 && int'(cnt_bytes) * 8 < int'(sel_req))
            begin
                r.size_error = 1'b1;
            end
            else
            begin
                if (w > 0)
                begin
                    v = acc_bits;
                    if (sel_sext && w < 32 && v[w-1])
                        v = v | ~((32'd1 << w) - 32'd1);
                    if (v != held_value)
                    begin
                        held_value      = v;
                        r.value_changed = 1'b1;
                    end
                end
                if (r.value_changed || sel_rel)
                begin
                    evt_time    = ts;
                    r.event_res = 1'b1;
                end
                gen_count = gen_count + 32'd2;
                r.handled = 1'b1;
            end
        end
        cnt_bytes     = '0;
        acc_bits      = '0;
        r.field_value = held_value;
        r.generation  = gen_count;
        r.change_time = evt_time;
    endtask

    task automatic push_byte(input logic [7:0] tag, input logic [7:0] data, input logic last,
                             input logic [31:0] ts, input bit typed, input result_t want);
        result_t r;
        bit      done;
        int      gap;
        if (!quiet && $urandom_range(99) < STALL_PCT)
        begin
            gap = $urandom_range(1, 4);
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        report_tag <= tag;
        data_byte  <= data;
        last_byte  <= last;
        time_stamp <= ts;
        do @(posedge clk); while (byte_stall);
        bytes_taken++;
        extract_field(tag, data, last, ts, done, r);
        if (done)
            pending_results.push_back(typed ? want : r);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        store_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every request in flight has produced its result.
    task automatic drain();
        byte_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic stim_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t s;
        s        = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        return s;
    endfunction

    function automatic stim_row_t byte_row(input logic [7:0] tag, input logic [7:0] data,
                                           input logic last, input logic [31:0] ts);
        stim_row_t s;
        s      = '{default: '0};
        s.tag  = tag;
        s.data = data;
        s.last = last;
        s.ts   = ts;
        return s;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] tag, input logic [7:0] data,
                                            input logic [31:0] ts, input logic h, input logic se,
                                            input logic ch, input logic ev, input logic [31:0] val,
                                            input logic [31:0] gen, input logic [31:0] ct);
        stim_row_t s;
        s       = byte_row(tag, data, 1'b1, ts);
        s.typed = 1'b1;
        s.want  = '{h, se, ch, ev, val, gen, ct};
        return s;
    endfunction

    // Picks a register setting for one phase and writes all of it.
    task automatic apply_setting(input int ph, output int span, output bit longr);
        logic [9:0] id_v, start_v, width_v, sext_v, rel_v, req_v;
        longr = (ph == 0 || ph == 2 || $urandom_range(9) == 0);
        span  = longr ? MAX_REPORT_BYTES_DEF : $urandom_range(1, 8);
        case (ph)
            0:
            begin
                id_v = 10'h0FF; start_v = 10'h1FF; width_v = 10'd63;
                sext_v = 10'd1; rel_v = 10'd1; req_v = 10'h3FF;
            end
            1:
            begin
                id_v = '0; start_v = '0; width_v = '0; sext_v = '0; rel_v = '0; req_v = '0;
            end
            2:
            begin
                id_v = 10'($urandom_range(255)); start_v = 10'd504; width_v = 10'd32;
                sext_v = 10'd1; rel_v = 10'd0; req_v = 10'd512;
            end
            default:
            begin
                id_v    = 10'($urandom_range(255));
                start_v = ($urandom_range(9) == 0) ? 10'($urandom_range(448, 511))
                                                   : 10'($urandom_range(0, span * 8));
                case ($urandom_range(9))
                    0: width_v = '0;
                    1: width_v = 10'($urandom_range(33, 63));
                    default: width_v = 10'($urandom_range(1, 32));
                endcase
                sext_v = 10'($urandom_range(1));
                rel_v  = 10'($urandom_range(1));
                case ($urandom_range(11))
                    0: req_v = 10'($urandom_range(513, 1023));
                    1, 2, 3, 4, 5: req_v = '0;
                    default: req_v = 10'($urandom_range(1, span * 8 + 16));
                endcase
                // Upper bits beyond a register's width must be dropped by the block.
                if ($urandom_range(3) == 0)
                begin
                    id_v    = id_v    | (10'($urandom) & ~10'h0FF);
                    start_v = start_v | (10'($urandom) & ~10'h1FF);
                    width_v = width_v | (10'($urandom) & ~10'h03F);
                    sext_v  = sext_v  | (10'($urandom) & ~10'h001);
                    rel_v   = rel_v   | (10'($urandom) & ~10'h001);
                end
            end
        endcase
        write_reg(REG_MATCH_ID, id_v);
        write_reg(REG_START_BIT, start_v);
        write_reg(REG_FIELD_WIDTH, width_v);
        write_reg(REG_SIGN_EXTEND, sext_v);
        write_reg(REG_RELATIVE_MODE, rel_v);
        write_reg(REG_REQUIRED_BITS, req_v);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 10'($urandom));
    endtask

    // Receiver: random stalls, plus one long hold-off when the sender asks for it.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (hold_served < hold_asks)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                flag("unexpected result, field_value", field_value, 32'h0);
            end
            else
            begin
                e = pending_results.pop_front();
                if (handled !== e.handled)             flag("handled", handled, e.handled);
                if (size_error !== e.size_error)       flag("size_error", size_error, e.size_error);
                if (value_changed !== e.value_changed)
                    flag("value_changed", value_changed, e.value_changed);
                if (event_res !== e.event_res)         flag("event_res", event_res, e.event_res);
                if (field_value !== e.field_value)     flag("field_value", field_value, e.field_value);
                if (generation !== e.generation)       flag("generation", generation, e.generation);
                if (change_time !== e.change_time)     flag("change_time", change_time, e.change_time);
                n_handled += e.handled;
                n_short   += e.size_error;
                n_other   += !(e.handled || e.size_error);
                n_events  += e.event_res;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL hid_report_field_extractor");
            $finish;
        end
    end

    initial
    begin
        int         ph;
        int         span;
        int         nrep;
        int         len;
        bit         longr;
        logic [7:0] tag;

        // Reset setting, then max ID with an oversized write, full-width sign handling,
        // short reports, zero width with relative mode, width saturation and unused indexes.
        directed.push_back(typed_row(8'h00, 8'h01, 32'h10, 1, 0, 1, 1, 32'h1, 32'd2, 32'h10));
        directed.push_back(typed_row(8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'h1, 32'd2, 32'h10));
        directed.push_back(cfg_row(REG_MATCH_ID, 10'h3FF));
        directed.push_back(cfg_row(REG_FIELD_WIDTH, 10'd32));
        directed.push_back(cfg_row(REG_SIGN_EXTEND, 10'd1));
        directed.push_back(byte_row(8'hFF, 8'h00, 1'b0, 32'h0));
        directed.push_back(byte_row(8'hFF, 8'h00, 1'b0, 32'h0));
        directed.push_back(byte_row(8'hFF, 8'h00, 1'b0, 32'h0));
        directed.push_back(typed_row(8'hFF, 8'h80, 32'hFFFF_FFFF, 1, 0, 1, 1,
                                     32'h8000_0000, 32'd4, 32'hFFFF_FFFF));
        directed.push_back(cfg_row(REG_REQUIRED_BITS, 10'd512));
        directed.push_back(byte_row(8'hFF, 8'hFF, 1'b0, 32'h5));
        directed.push_back(typed_row(8'hFF, 8'hFF, 32'h6, 0, 1, 0, 0,
                                     32'h8000_0000, 32'd4, 32'hFFFF_FFFF));
        directed.push_back(cfg_row(REG_REQUIRED_BITS, 10'h3FF));
        directed.push_back(typed_row(8'hFF, 8'h00, 32'h7, 0, 1, 0, 0,
                                     32'h8000_0000, 32'd4, 32'hFFFF_FFFF));
        directed.push_back(typed_row(8'h00, 8'h00, 32'h8, 0, 0, 0, 0,
                                     32'h8000_0000, 32'd4, 32'hFFFF_FFFF));
        directed.push_back(cfg_row(REG_REQUIRED_BITS, 10'd0));
        directed.push_back(cfg_row(REG_FIELD_WIDTH, 10'd0));
        directed.push_back(cfg_row(REG_RELATIVE_MODE, 10'd1));
        directed.push_back(cfg_row(REG_SPARE_6, 10'h3FF));
        directed.push_back(cfg_row(REG_SPARE_7, 10'h3FF));
        directed.push_back(typed_row(8'hFF, 8'hFF, 32'h1234, 1, 0, 0, 1,
                                     32'h8000_0000, 32'd6, 32'h1234));
        directed.push_back(cfg_row(REG_RELATIVE_MODE, 10'd0));
        directed.push_back(cfg_row(REG_START_BIT, 10'd4));
        directed.push_back(cfg_row(REG_FIELD_WIDTH, 10'd4));
        directed.push_back(byte_row(8'hFF, 8'hF0, 1'b1, 32'h100));
        directed.push_back(cfg_row(REG_FIELD_WIDTH, 10'd5));
        directed.push_back(byte_row(8'hFF, 8'hF0, 1'b1, 32'h101));
        directed.push_back(cfg_row(REG_START_BIT, 10'd0));
        directed.push_back(cfg_row(REG_FIELD_WIDTH, 10'd63));
        directed.push_back(byte_row(8'hFF, 8'hAA, 1'b0, 32'h0));
        directed.push_back(byte_row(8'hFF, 8'h55, 1'b0, 32'h0));
        directed.push_back(byte_row(8'hFF, 8'hAA, 1'b0, 32'h0));
        directed.push_back(byte_row(8'hFF, 8'h55, 1'b1, 32'h200));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            if (directed[k].is_cfg)
            begin
                drain();
                write_reg(directed[k].idx, directed[k].val);
            end
            else
            begin
                push_byte(directed[k].tag, directed[k].data, directed[k].last, directed[k].ts,
                          directed[k].typed, directed[k].want);
            end
        end

        ph = 0;
        while (bytes_taken < ITEM_TARGET)
        begin
            drain();
            apply_setting(ph, span, longr);
            quiet = (ph == 2 || ph == 3);
            if (ph == 1)
            begin
                // Back-to-back one-byte reports against a held receiver fill the block.
                quiet = 1'b1;
                hold_asks++;
                for (int n = 0; n < 24; n++)
                    push_byte(sel_id, 8'($urandom), 1'b1, $urandom, 1'b0, '0);
                quiet = 1'b0;
            end
            nrep = longr ? $urandom_range(2, 4) : $urandom_range(4, 12);
            for (int n = 0; n < nrep; n++)
            begin
                len = longr ? $urandom_range(56, 72) : $urandom_range(1, span + 1);
                tag = ($urandom_range(99) < 85) ? sel_id : 8'($urandom_range(255));
                for (int b = 0; b < len; b++)
                begin
                    // Only the tag of the final byte is looked at.
                    push_byte((b < len - 1 && $urandom_range(9) == 0) ? 8'($urandom) : tag,
                              8'($urandom), (b == len - 1), $urandom, 1'b0, '0);
                end
                if (bytes_taken >= ITEM_TARGET)
                    break;
            end
            ph++;
        end
        quiet = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            flag("results never produced", pending_results.size(), 32'h0);

        $display("Ran %0d report bytes under %0d register settings, reports up to 72 bytes.",
                 bytes_taken, ph);
        $display("Checked %0d handled, %0d short and %0d foreign-ID reports, %0d events.",
                 n_handled, n_short, n_other, n_events);
        if (mismatches == 0)
            $display("PASS hid_report_field_extractor");
        else
            $display("FAIL hid_report_field_extractor");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/hrfe_pkg.sv
rtl/core/hid_report_field_extractor.sv
tb/sv/tb.sv
